// ----- hdl/mtm_pkg.sv -----
// shared types and constants for the message tag matcher
package mtm_pkg;

    localparam logic KIND_RECV   = 1'b0;
    localparam logic KIND_HEADER = 1'b1;

    typedef struct packed {
        logic load;     // capture input item, start search
        logic commit;   // apply queue update, register result
    } mtm_cmd_t;

endpackage

// ----- hdl/message_tag_matcher_unit.sv -----
// top level of the message tag matcher
// Two ordered queues for tag matching: posted receives (with source and
// tag wildcards) and unexpected message headers. s_kind=0 posts a
// receive, which searches the unexpected queue; s_kind=1 is an arriving
// header, which searches the posted receives. The oldest match is
// removed and reported on the m_ channel; on a miss the item is appended
// to its own queue (m_queued) or reported as m_dropped when it is full.
// Each input transfer gives exactly one result transfer.
// An item is handled in a load step, which compares all queue cells in
// parallel and registers the hits, and a commit step, which compacts the
// queue and registers the result; a new item is taken only after commit.
// The result sits in an output register; the next item is taken and
// compared while it waits, and its commit stalls until the result is
// transferred.
// Reset (aresetn, synchronous, active low) empties both queues.
module message_tag_matcher_unit #(
    parameter int QUEUE_DEPTH = 32,
    parameter int MAX_RANKS   = 64,
    parameter int TAG_BITS    = 15,
    parameter int HANDLE_BITS = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [$clog2(MAX_RANKS)-1:0] s_source,
    input  logic [TAG_BITS-1:0]          s_tag,
    input  logic                         s_any_source,
    input  logic                         s_any_tag,
    input  logic [HANDLE_BITS-1:0]       s_handle,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_matched,
    output logic [HANDLE_BITS-1:0]       m_matched_handle,
    output logic [$clog2(MAX_RANKS)-1:0] m_matched_source,
    output logic [TAG_BITS-1:0]          m_matched_tag,
    output logic                         m_queued,
    output logic                         m_dropped
);
    import mtm_pkg::*;

    mtm_cmd_t cmd;

    mtm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    mtm_datapath #(
        .DEPTH (QUEUE_DEPTH),
        .SRC_W ($clog2(MAX_RANKS)),
        .TAG_W (TAG_BITS),
        .HND_W (HANDLE_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .s_kind           (s_kind),
        .s_source         (s_source),
        .s_tag            (s_tag),
        .s_any_source     (s_any_source),
        .s_any_tag        (s_any_tag),
        .s_handle         (s_handle),
        .m_matched        (m_matched),
        .m_matched_handle (m_matched_handle),
        .m_matched_source (m_matched_source),
        .m_matched_tag    (m_matched_tag),
        .m_queued         (m_queued),
        .m_dropped        (m_dropped)
    );
endmodule

// ----- hdl/mtm_ctrl.sv -----
// controller state machine for the message tag matcher
module mtm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output mtm_pkg::mtm_cmd_t cmd
);
    import mtm_pkg::*;

    localparam logic [0:0] ST_IDLE   = 1'b0;
    localparam logic [0:0] ST_SEARCH = 1'b1;

    logic [0:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    // result register may hold while next item is searched
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        cmd.load    = 1'b0;
        cmd.commit  = 1'b0;
        if (m_valid && m_ready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (!mvalid_reg || m_ready) begin
                    cmd.commit  = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end
endmodule

// ----- hdl/mtm_datapath.sv -----
// queue cells, parallel match, compaction and result register
module mtm_datapath #(
    parameter int DEPTH  = 32,
    parameter int SRC_W  = 6,
    parameter int TAG_W  = 15,
    parameter int HND_W  = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mtm_pkg::mtm_cmd_t cmd,
    input  logic              s_kind,
    input  logic [SRC_W-1:0]  s_source,
    input  logic [TAG_W-1:0]  s_tag,
    input  logic              s_any_source,
    input  logic              s_any_tag,
    input  logic [HND_W-1:0]  s_handle,
    output logic              m_matched,
    output logic [HND_W-1:0]  m_matched_handle,
    output logic [SRC_W-1:0]  m_matched_source,
    output logic [TAG_W-1:0]  m_matched_tag,
    output logic              m_queued,
    output logic              m_dropped
);
    import mtm_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic [SRC_W-1:0] source;
        logic [TAG_W-1:0] tag;
        logic             any_source;
        logic             any_tag;
        logic [HND_W-1:0] handle;
    } ent_t;

    ent_t          pq_reg [DEPTH];
    ent_t          uq_reg [DEPTH];
    logic [CW-1:0] pcnt_reg, ucnt_reg;
    ent_t          item_reg;
    logic          kind_reg;
    logic [DEPTH-1:0] hit_reg;

    logic          matched_reg, queued_reg, dropped_reg;
    logic [HND_W-1:0] mhnd_reg;
    logic [SRC_W-1:0] msrc_reg;
    logic [TAG_W-1:0] mtag_reg;

    assign m_matched        = matched_reg;
    assign m_matched_handle = mhnd_reg;
    assign m_matched_source = msrc_reg;
    assign m_matched_tag    = mtag_reg;
    assign m_queued         = queued_reg;
    assign m_dropped        = dropped_reg;

    // per-cell compare against the input item, registered at load
    logic [DEPTH-1:0] hit_cmp;
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (s_kind == KIND_RECV) begin
                hit_cmp[i] = (CW'(i) < ucnt_reg)
                    && (s_any_source || uq_reg[i].source == s_source)
                    && (s_any_tag || uq_reg[i].tag == s_tag);
            end else begin
                hit_cmp[i] = (CW'(i) < pcnt_reg)
                    && (pq_reg[i].any_source || pq_reg[i].source == s_source)
                    && (pq_reg[i].any_tag || pq_reg[i].tag == s_tag);
            end
        end
    end

    // isolate oldest hit; cells at or above it shift down
    logic [DEPTH-1:0] first_hit, at_or_above;
    logic             any_hit;
    ent_t             found;
    always_comb begin
        first_hit   = hit_reg & (~hit_reg + DEPTH'(1));
        at_or_above = ~(first_hit - DEPTH'(1));
        any_hit     = |hit_reg;
        found       = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first_hit[i]) begin
                found = (kind_reg == KIND_RECV) ? uq_reg[i] : pq_reg[i];
            end
        end
    end

    logic full_tgt;
    assign full_tgt = (kind_reg == KIND_RECV) ? (pcnt_reg == CW'(DEPTH))
                                              : (ucnt_reg == CW'(DEPTH));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg.source     <= s_source;
            item_reg.tag        <= s_tag;
            item_reg.any_source <= s_any_source && (s_kind == KIND_RECV);
            item_reg.any_tag    <= s_any_tag && (s_kind == KIND_RECV);
            item_reg.handle     <= s_handle;
            kind_reg            <= s_kind;
            hit_reg             <= hit_cmp;
        end
        if (cmd.commit) begin
            matched_reg <= any_hit;
            queued_reg  <= !any_hit && !full_tgt;
            dropped_reg <= !any_hit && full_tgt;
            mhnd_reg    <= any_hit ? found.handle : '0;
            msrc_reg    <= any_hit ? found.source : '0;
            mtag_reg    <= any_hit ? found.tag : '0;
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (any_hit && at_or_above[i]) begin
                    if (kind_reg == KIND_RECV) begin
                        uq_reg[i] <= uq_reg[i+1];
                    end else begin
                        pq_reg[i] <= pq_reg[i+1];
                    end
                end
            end
            if (!any_hit && !full_tgt) begin
                if (kind_reg == KIND_RECV) begin
                    pq_reg[pcnt_reg[IW-1:0]] <= item_reg;
                end else begin
                    uq_reg[ucnt_reg[IW-1:0]] <= item_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcnt_reg <= '0;
            ucnt_reg <= '0;
        end else if (cmd.commit) begin
            if (kind_reg == KIND_RECV) begin
                if (any_hit) ucnt_reg <= ucnt_reg - CW'(1);
                else if (!full_tgt) pcnt_reg <= pcnt_reg + CW'(1);
            end else begin
                if (any_hit) pcnt_reg <= pcnt_reg - CW'(1);
                else if (!full_tgt) ucnt_reg <= ucnt_reg + CW'(1);
            end
        end
    end
endmodule
